[hw/rtl/daa_pkg.sv]
// Package for the daily activity aggregator.
// Holds item, result and configuration types plus fixed constants.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none
package daa_pkg;

   localparam int unsigned HOURS_PER_DAY    = 24;
   localparam int unsigned MINUTES_PER_HOUR = 60;
   localparam logic [10:0] MAX_ACTIVE_MINUTES = 11'(HOURS_PER_DAY * MINUTES_PER_HOUR);

   localparam logic [1:0] MODE_STEP    = 2'd0;
   localparam logic [1:0] MODE_TIME    = 2'd1;
   localparam logic [1:0] MODE_CONSUME = 2'd2;

   localparam logic [2:0] CSR_STAND_STEPS  = 3'd0;
   localparam logic [2:0] CSR_CADENCE      = 3'd1;
   localparam logic [2:0] CSR_START_HOUR   = 3'd2;
   localparam logic [2:0] CSR_END_HOUR     = 3'd3;
   localparam logic [2:0] CSR_INACT_LIMIT  = 3'd4;

   typedef struct packed {
      logic [1:0]  mode;
      logic [15:0] step_count;
      logic [31:0] now_ms;
      logic [24:0] day_number;
      logic [4:0]  hour;
      logic [5:0]  minute;
   } req_type;

   typedef struct packed {
      logic [31:0] steps_today;
      logic [10:0] active_minutes_today;
      logic [23:0] stood_hours;
      logic        alert_pending;
      logic        alert_taken;
   } rsp_type;

   typedef struct packed {
      logic [15:0] stand_steps_per_hour;
      logic [15:0] active_cadence;
      logic [4:0]  alert_first_hour;
      logic [4:0]  alert_stop_hour;
      logic [31:0] inactivity_limit_ms;
   } cfg_type;

   function automatic logic [31:0] sat_add(input logic [31:0] a, input logic [15:0] b);
      logic [32:0] s;
      s = {1'b0, a} + {17'd0, b};
      return s[32] ? 32'hFFFF_FFFF : s[31:0];
   endfunction

endpackage
`default_nettype wire

[hw/rtl/daa_cfg.sv]
// Configuration registers of the daily activity aggregator.
// Depends on daa_pkg for the register indexes and cfg_type.
`timescale 1ns / 1ps
`default_nettype none
module daa_cfg
   import daa_pkg::*;
(
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        csr_valid,
   input  wire logic [2:0]  csr_index,
   input  wire logic [31:0] csr_data,
   output cfg_type          cfg
);

   cfg_type cfg_ff;
   cfg_type cfg_in;

   always_comb begin
      cfg_in = cfg_ff;
      if (csr_valid) begin
         case (csr_index)
            CSR_STAND_STEPS: cfg_in.stand_steps_per_hour = csr_data[15:0];
            CSR_CADENCE:     cfg_in.active_cadence       = csr_data[15:0];
            CSR_START_HOUR:  cfg_in.alert_first_hour     = csr_data[4:0];
            CSR_END_HOUR:    cfg_in.alert_stop_hour      = csr_data[4:0];
            CSR_INACT_LIMIT: cfg_in.inactivity_limit_ms  = csr_data;
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.stand_steps_per_hour <= 16'd250;
         cfg_ff.active_cadence       <= 16'd100;
         cfg_ff.alert_first_hour     <= 5'd8;
         cfg_ff.alert_stop_hour      <= 5'd22;
         cfg_ff.inactivity_limit_ms  <= 32'd3600000;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   assign cfg = cfg_ff;

endmodule
`default_nettype wire

[hw/rtl/daa_state.sv]
// Activity state registers and the single-pass update for one item.
// Depends on daa_pkg for item, result and configuration types.
`timescale 1ns / 1ps
`default_nettype none
module daa_state
   import daa_pkg::*;
(
   input  wire logic    clock,
   input  wire logic    reset,
   input  wire logic    upd_en,
   input  wire req_type item,
   input  wire cfg_type cfg,
   output rsp_type      result
);

   logic [31:0] day_steps_ff, day_steps_in;
   logic [31:0] minute_steps_ff, minute_steps_in;
   logic [31:0] hour_steps_ff, hour_steps_in;
   logic [10:0] active_total_ff, active_total_in;
   logic [23:0] stood_mask_ff, stood_mask_in;
   logic [24:0] current_day_ff, current_day_in;
   logic        day_known_ff, day_known_in;
   logic [4:0]  current_hour_ff, current_hour_in;
   logic        hour_known_ff, hour_known_in;
   logic [10:0] last_mod_ff, last_mod_in;
   logic        minute_known_ff, minute_known_in;
   logic [31:0] last_step_ff, last_step_in;
   logic        step_seen_ff, step_seen_in;
   logic        alert_fired_ff, alert_fired_in;
   logic        alert_wait_ff, alert_wait_in;
   logic        taken;
   logic [10:0] mod;
   logic [31:0] silence;

   assign mod     = 11'(item.hour * 11'(MINUTES_PER_HOUR)) + {5'd0, item.minute};
   assign silence = item.now_ms - last_step_ff;

   always_comb begin
      day_steps_in    = day_steps_ff;
      minute_steps_in = minute_steps_ff;
      hour_steps_in   = hour_steps_ff;
      active_total_in = active_total_ff;
      stood_mask_in   = stood_mask_ff;
      current_day_in  = current_day_ff;
      day_known_in    = day_known_ff;
      current_hour_in = current_hour_ff;
      hour_known_in   = hour_known_ff;
      last_mod_in     = last_mod_ff;
      minute_known_in = minute_known_ff;
      last_step_in    = last_step_ff;
      step_seen_in    = step_seen_ff;
      alert_fired_in  = alert_fired_ff;
      alert_wait_in   = alert_wait_ff;
      taken           = 1'b0;
      case (item.mode)
         MODE_STEP: begin
            day_steps_in    = sat_add(day_steps_ff, item.step_count);
            minute_steps_in = sat_add(minute_steps_ff, item.step_count);
            hour_steps_in   = sat_add(hour_steps_ff, item.step_count);
            last_step_in    = item.now_ms;
            step_seen_in    = 1'b1;
            alert_fired_in  = 1'b0;
            if (hour_known_ff && hour_steps_in >= {16'd0, cfg.stand_steps_per_hour}
                && current_hour_ff < 5'(HOURS_PER_DAY)) begin
               stood_mask_in = stood_mask_ff | (24'd1 << current_hour_ff);
            end
         end
         MODE_TIME: begin
            if (!day_known_ff) begin
               current_day_in = item.day_number;
               day_known_in   = 1'b1;
            end else if (item.day_number != current_day_ff) begin
               day_steps_in    = '0;
               active_total_in = '0;
               minute_steps_in = '0;
               hour_steps_in   = '0;
               stood_mask_in   = '0;
               alert_fired_in  = 1'b0;
               current_day_in  = item.day_number;
            end
            if (!hour_known_ff) begin
               current_hour_in = item.hour;
               hour_known_in   = 1'b1;
            end else if (item.hour != current_hour_ff) begin
               current_hour_in = item.hour;
               hour_steps_in   = '0;
            end
            if (!minute_known_ff) begin
               last_mod_in     = mod;
               minute_known_in = 1'b1;
            end else if (mod != last_mod_ff) begin
               if (minute_steps_in >= {16'd0, cfg.active_cadence}
                   && active_total_in < MAX_ACTIVE_MINUTES) begin
                  active_total_in = active_total_in + 11'd1;
               end
               minute_steps_in = '0;
               last_mod_in     = mod;
            end
            if (!alert_fired_in && item.hour >= cfg.alert_first_hour
                && item.hour < cfg.alert_stop_hour && step_seen_ff
                && silence > cfg.inactivity_limit_ms) begin
               alert_fired_in = 1'b1;
               alert_wait_in  = 1'b1;
            end
         end
         MODE_CONSUME: begin
            if (alert_wait_ff) begin
               alert_wait_in = 1'b0;
               taken         = 1'b1;
            end
         end
         default: ;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         day_steps_ff    <= '0;
         minute_steps_ff <= '0;
         hour_steps_ff   <= '0;
         active_total_ff <= '0;
         stood_mask_ff   <= '0;
         current_day_ff  <= '0;
         day_known_ff    <= 1'b0;
         current_hour_ff <= '0;
         hour_known_ff   <= 1'b0;
         last_mod_ff     <= '0;
         minute_known_ff <= 1'b0;
         last_step_ff    <= '0;
         step_seen_ff    <= 1'b0;
         alert_fired_ff  <= 1'b0;
         alert_wait_ff   <= 1'b0;
      end else if (upd_en) begin
         day_steps_ff    <= day_steps_in;
         minute_steps_ff <= minute_steps_in;
         hour_steps_ff   <= hour_steps_in;
         active_total_ff <= active_total_in;
         stood_mask_ff   <= stood_mask_in;
         current_day_ff  <= current_day_in;
         day_known_ff    <= day_known_in;
         current_hour_ff <= current_hour_in;
         hour_known_ff   <= hour_known_in;
         last_mod_ff     <= last_mod_in;
         minute_known_ff <= minute_known_in;
         last_step_ff    <= last_step_in;
         step_seen_ff    <= step_seen_in;
         alert_fired_ff  <= alert_fired_in;
         alert_wait_ff   <= alert_wait_in;
      end
   end

   assign result.steps_today          = day_steps_in;
   assign result.active_minutes_today = active_total_in;
   assign result.stood_hours          = stood_mask_in;
   assign result.alert_pending        = alert_wait_in;
   assign result.alert_taken          = taken;

endmodule
`default_nettype wire

[hw/rtl/daily_activity_aggregator_core.sv]
// An accepted item passes through the input register and then the result register,
// which drives rsp_valid; the state update sits between the two registers.
// Throughput: one item per cycle while the result is not stalled.
// req_stall rises only while an item waits in the input register behind a stalled result.
// Reset (synchronous, active high) empties both registers, clears all activity state
// and loads the configuration registers with their defaults.
`timescale 1ns / 1ps
`default_nettype none
module daily_activity_aggregator_core
   import daa_pkg::*;
(
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        req_valid,
   output logic             req_stall,
   input  wire req_type     req_item,
   output logic             rsp_valid,
   input  wire logic        rsp_stall,
   output rsp_type          rsp_item,
   input  wire logic        csr_valid,
   output logic             csr_ready,
   input  wire logic [2:0]  csr_index,
   input  wire logic [31:0] csr_data
);

   req_type in_ff;
   logic    in_vld_ff, in_vld_in;
   rsp_type out_ff;
   logic    out_vld_ff, out_vld_in;
   rsp_type result;
   cfg_type cfg;
   logic    out_open;
   logic    advance;
   logic    load;

   assign csr_ready = 1'b1;

   daa_cfg u_cfg (
      .clock     (clock),
      .reset     (reset),
      .csr_valid (csr_valid),
      .csr_index (csr_index),
      .csr_data  (csr_data),
      .cfg       (cfg)
   );

   daa_state u_state (
      .clock  (clock),
      .reset  (reset),
      .upd_en (advance),
      .item   (in_ff),
      .cfg    (cfg),
      .result (result)
   );

   assign out_open  = !out_vld_ff || !rsp_stall;
   assign advance   = in_vld_ff && out_open;
   assign req_stall = in_vld_ff && !out_open;
   assign load      = req_valid && !req_stall;

   always_comb begin
      in_vld_in = in_vld_ff;
      if (load) begin
         in_vld_in = 1'b1;
      end else if (advance) begin
         in_vld_in = 1'b0;
      end
      out_vld_in = out_vld_ff;
      if (advance) begin
         out_vld_in = 1'b1;
      end else if (!rsp_stall) begin
         out_vld_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_vld_ff  <= 1'b0;
         out_vld_ff <= 1'b0;
      end else begin
         in_vld_ff  <= in_vld_in;
         out_vld_ff <= out_vld_in;
      end
   end

   always_ff @(posedge clock) begin
      if (load) begin
         in_ff <= req_item;
      end
      if (advance) begin
         out_ff <= result;
      end
   end

   assign rsp_valid = out_vld_ff;
   assign rsp_item  = out_ff;

endmodule
`default_nettype wire

[hw/rtl/daa_checker.sv]
// Port-level checks for daily_activity_aggregator_core, attached by bind.
// Depends on daa_pkg for the item and result types.
`timescale 1ns / 1ps
`default_nettype none
module daa_checker
   import daa_pkg::*;
(
   input wire logic    clock,
   input wire logic    reset,
   input wire logic    req_stall,
   input wire logic    rsp_valid,
   input wire logic    rsp_stall,
   input wire rsp_type rsp_item
);

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid)
      else $error("result dropped while stalled");

   a_rsp_stable: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> $stable(rsp_item))
      else $error("stalled result changed");

   a_stall_cause: assert property (@(posedge clock) disable iff (reset)
      req_stall |-> rsp_valid && rsp_stall)
      else $error("input stalled without a stalled result");

   a_taken_clears: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_item.alert_taken |-> !rsp_item.alert_pending)
      else $error("alert taken but still pending");

   a_minutes_cap: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> rsp_item.active_minutes_today <= MAX_ACTIVE_MINUTES)
      else $error("active minutes above a full day");

endmodule

bind daily_activity_aggregator_core daa_checker u_daa_checker (
   .clock     (clock),
   .reset     (reset),
   .req_stall (req_stall),
   .rsp_valid (rsp_valid),
   .rsp_stall (rsp_stall),
   .rsp_item  (rsp_item)
);
`default_nettype wire
